// ===== hdl/nearest_palette_color_classifier_top_assert.svh =====
// Assertion macros for the nearest palette color classifier.
// Used by the top level only; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_CLASSIFIER_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTH
`define NPCC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("npcc assertion failed");
`define NPCC_ASSERT_DELAY(lbl, clk, rstn, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
        else $error("npcc assertion failed");
`else
`define NPCC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define NPCC_ASSERT_DELAY(lbl, clk, rstn, ante, n, cons)
`endif

`endif

// ===== hdl/npcc_pkg.sv =====
// Shared constants, types and palette function for the nearest palette color classifier.
// No dependencies.
package npcc_pkg;

    localparam int NUM_COLORS   = 10;
    localparam int FRAC_BITS    = 10;
    localparam int PALETTE_SIZE = 10;
    localparam int LIMIT        = (NUM_COLORS < PALETTE_SIZE) ? NUM_COLORS : PALETTE_SIZE;

    localparam int NUM_CH     = 3;
    localparam int CNT_W      = 16;
    localparam int NORM_W     = FRAC_BITS + 1;
    localparam int DIST_W     = 2 * NORM_W;
    localparam int IDX_W      = 4;
    localparam int DIST_OUT_W = 22;

    localparam int DIV_STAGES  = NORM_W;
    localparam int TREE_LEVELS = $clog2(PALETTE_SIZE);
    localparam int TREE_N      = 1 << TREE_LEVELS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int FRONT_LAT = DIV_STAGES + 1;
    localparam int QUEUE_LAT = 1;
    localparam int BACK_LAT  = 2 + TREE_LEVELS;
    localparam int TOTAL_LAT = FRONT_LAT + QUEUE_LAT + BACK_LAT;

    localparam logic [3:0] PALETTE_TENTHS [PALETTE_SIZE][NUM_CH] = '{
        '{4'd10, 4'd0,  4'd0 },
        '{4'd0,  4'd10, 4'd0 },
        '{4'd0,  4'd0,  4'd10},
        '{4'd10, 4'd10, 4'd0 },
        '{4'd10, 4'd5,  4'd0 },
        '{4'd5,  4'd0,  4'd10},
        '{4'd0,  4'd5,  4'd10},
        '{4'd10, 4'd0,  4'd10},
        '{4'd3,  4'd3,  4'd0 },
        '{4'd10, 4'd10, 4'd10}
    };

    typedef struct packed {
        logic [CNT_W-1:0] red_count;
        logic [CNT_W-1:0] green_count;
        logic [CNT_W-1:0] blue_count;
        logic [CNT_W-1:0] clear_count;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]      color_index;
        logic [DIST_OUT_W-1:0] distance_sq;
    } result_t;

    typedef struct packed {
        logic [NUM_CH-1:0][NORM_W-1:0] ch;
    } norm_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic                          zero;
        logic [CNT_W-1:0]              divisor;
        logic [NUM_CH-1:0][CNT_W-1:0]  rem;
        logic [NUM_CH-1:0][NORM_W-1:0] quo;
    } div_stage_t;

    typedef struct packed {
        logic              present;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
    } cand_t;

    // Palette component in fixed point, rounded half up from tenths.
    function automatic logic [NORM_W-1:0] palette_fixed(input int entry, input int chan);
        int scaled;
        scaled = (int'(PALETTE_TENTHS[entry][chan]) << FRAC_BITS) + 5;
        return NORM_W'(scaled / 10);
    endfunction

endpackage

// ===== hdl/nearest_palette_color_classifier_top.sv =====
// Top level of the nearest palette color classifier.
// Uses npcc_pkg, npcc_front, npcc_fifo, npcc_back and the assertion macro header.

// Takes one sensor item per clock when start is high and busy is low, and
// delivers its result on result with result_valid high for exactly one cycle,
// after the item has passed through the front end, whose divider pipeline
// retires one quotient bit per stage, then the queue, and then the registered
// distance units and the minimum tree. Items with a zero clear count produce
// no result. The back end never waits, so the queue does not fill and busy
// stays low; results come out in item order and must be taken in the cycle
// they appear.
`include "nearest_palette_color_classifier_top_assert.svh"

module nearest_palette_color_classifier_top
    import npcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    result_valid,
    output result_t result
);

    logic          accept;
    logic          lit_accept;
    logic          dark_accept;
    logic          front_valid;
    norm_t         front_norm;
    norm_t         queue_norm;
    queue_status_t queue_status;

    assign accept      = start && !busy;
    assign busy        = queue_status.full;
    assign lit_accept  = accept && (item.clear_count != '0);
    assign dark_accept = accept && (item.clear_count == '0);

    npcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .norm_valid (front_valid),
        .norm       (front_norm)
    );

    npcc_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_valid),
        .din    (front_norm),
        .pop    (!queue_status.empty),
        .dout   (queue_norm),
        .status (queue_status)
    );

    npcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (!queue_status.empty),
        .norm         (queue_norm),
        .result_valid (result_valid),
        .result       (result)
    );

    `NPCC_ASSERT_SAME(a_queue_never_full, clk, rst_n, 1'b1, !queue_status.full)
    `NPCC_ASSERT_SAME(a_index_in_range, clk, rst_n, result_valid, result.color_index < 4'd10)
    `NPCC_ASSERT_SAME(a_result_has_item, clk, rst_n, result_valid, $past(lit_accept, TOTAL_LAT))
    `NPCC_ASSERT_DELAY(a_zero_clear_silent, clk, rst_n, dark_accept, TOTAL_LAT, !result_valid)

endmodule

// ===== hdl/npcc_front.sv =====
// Front end: finds the largest color count and normalizes each channel by it
// through a restoring divider pipeline, one quotient bit per stage. Uses npcc_pkg.
module npcc_front
    import npcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item,
    output logic  norm_valid,
    output norm_t norm
);

    logic [CNT_W-1:0] max_rg;
    logic [CNT_W-1:0] max_rgb;
    logic [DIV_STAGES:0] valid_reg;
    logic [DIV_STAGES:0] valid_next;
    div_stage_t stage_reg [DIV_STAGES+1];

    function automatic logic [CNT_W:0] div_step(
        input logic [CNT_W-1:0] rem,
        input logic [CNT_W-1:0] divisor,
        input logic             first
    );
        logic [CNT_W:0] trial;
        logic [CNT_W:0] diff;
        trial = first ? {1'b0, rem} : {rem, 1'b0};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            return {1'b1, diff[CNT_W-1:0]};
        end
        return {1'b0, trial[CNT_W-1:0]};
    endfunction

    assign max_rg  = (item.green_count > item.red_count) ? item.green_count : item.red_count;
    assign max_rgb = (item.blue_count > max_rg) ? item.blue_count : max_rg;

    assign valid_next = {valid_reg[DIV_STAGES-1:0], accept && (item.clear_count != '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0].zero    <= (max_rgb == '0);
        stage_reg[0].divisor <= max_rgb;
        stage_reg[0].rem     <= {item.blue_count, item.green_count, item.red_count};
        stage_reg[0].quo     <= '0;
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_div
        div_stage_t     stage_next;
        logic [CNT_W:0] step_res [NUM_CH];

        always_comb
        begin
            stage_next = stage_reg[s-1];
            for (int k = 0; k < NUM_CH; k++)
            begin
                step_res[k] = div_step(stage_reg[s-1].rem[k], stage_reg[s-1].divisor,
                                       (s == 1));
                stage_next.rem[k] = step_res[k][CNT_W-1:0];
                stage_next.quo[k] = {stage_reg[s-1].quo[k][NORM_W-2:0], step_res[k][CNT_W]};
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[s] <= stage_next;
        end
    end

    assign norm_valid = valid_reg[DIV_STAGES];
    assign norm.ch    = stage_reg[DIV_STAGES].zero ? '0 : stage_reg[DIV_STAGES].quo;

endmodule

// ===== hdl/npcc_fifo.sv =====
// Short queue of normalized items between the front and back ends.
// Uses npcc_pkg.
module npcc_fifo
    import npcc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  norm_t         din,
    input  logic          pop,
    output norm_t         dout,
    output queue_status_t status
);

    norm_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout         = mem[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

// ===== hdl/npcc_back.sv =====
// Back end: squared distances to every palette entry and a registered minimum tree.
// Uses npcc_pkg.
module npcc_back
    import npcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  norm_t   norm,
    output logic    result_valid,
    output result_t result
);

    localparam int BACK_STAGES = BACK_LAT;

    logic [BACK_STAGES-1:0] valid_reg;
    logic [BACK_STAGES-1:0] valid_next;
    logic [DIST_W-1:0] sq_reg [LIMIT][NUM_CH];
    logic [DIST_W-1:0] sum_reg [LIMIT];
    cand_t leaf [TREE_N];
    cand_t node_reg [1:TREE_N-1];

    function automatic cand_t pick(input cand_t lo, input cand_t hi);
        if (hi.present && (!lo.present || (hi.dist_sq < lo.dist_sq)))
        begin
            return hi;
        end
        return lo;
    endfunction

    assign valid_next = {valid_reg[BACK_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar i = 0; i < LIMIT; i++)
    begin : g_ent
        for (genvar k = 0; k < NUM_CH; k++)
        begin : g_ch
            localparam logic [NORM_W-1:0] PAL = palette_fixed(i, k);
            logic [NORM_W-1:0] diff;

            assign diff = (norm.ch[k] >= PAL) ? norm.ch[k] - PAL : PAL - norm.ch[k];

            always_ff @(posedge clk)
            begin
                sq_reg[i][k] <= DIST_W'(diff) * DIST_W'(diff);
            end
        end

        always_ff @(posedge clk)
        begin
            sum_reg[i] <= sq_reg[i][0] + sq_reg[i][1] + sq_reg[i][2];
        end
    end

    for (genvar j = 0; j < TREE_N; j++)
    begin : g_leaf
        if (j < LIMIT)
        begin : g_used
            assign leaf[j] = '{present: 1'b1, idx: IDX_W'(j), dist_sq: sum_reg[j]};
        end
        else
        begin : g_pad
            assign leaf[j] = '{present: 1'b0, idx: IDX_W'(j), dist_sq: '0};
        end
    end

    for (genvar j = 1; j < TREE_N; j++)
    begin : g_node
        cand_t lo;
        cand_t hi;

        if (2 * j >= TREE_N)
        begin : g_from_leaf
            assign lo = leaf[2*j-TREE_N];
            assign hi = leaf[2*j+1-TREE_N];
        end
        else
        begin : g_from_node
            assign lo = node_reg[2*j];
            assign hi = node_reg[2*j+1];
        end

        always_ff @(posedge clk)
        begin
            node_reg[j] <= pick(lo, hi);
        end
    end

    assign result_valid       = valid_reg[BACK_STAGES-1];
    assign result.color_index = node_reg[1].idx;
    assign result.distance_sq = DIST_OUT_W'(node_reg[1].dist_sq);

endmodule
